// ===== hw/rtl/s3tc_block_texel_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// S3TC decoder assertion macros
// Shared concurrent assertion forms used by the decoder's texel generator.
// ----------------------------------------------------------------------------
`ifndef S3TC_BLOCK_TEXEL_DECODER_ASSERT_SVH
`define S3TC_BLOCK_TEXEL_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define S3TCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define S3TCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/s3tcd_pkg.sv =====
// ----------------------------------------------------------------------------
// S3TC decoder package
// Types, register indexes and palette arithmetic shared by the decoder.
// ----------------------------------------------------------------------------
package s3tcd_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_t;

  localparam logic [1:0] CFG_FORMAT_MODE  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // reciprocal constants for exact floor division over the value ranges used
  localparam int DIV3_SH  = 11;
  localparam int DIV3_MUL = (1 << DIV3_SH) / 3 + 1;
  localparam int DIV5_SH  = 13;
  localparam int DIV5_MUL = (1 << DIV5_SH) / 5 + 1;
  localparam int DIV7_SH  = 14;
  localparam int DIV7_MUL = (1 << DIV7_SH) / 7 + 1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // everything the texel stage needs for one block
  typedef struct packed {
    color_t [3:0]      pal;
    logic              three_color;
    fmt_t              mode;
    logic [15:0][1:0]  cidx;
    logic [63:0]       aw;
    logic [7:0][7:0]   atab;
    logic [13:0]       col;
    logic [13:0]       row;
    logic [1:0]        ncols_m1;
    logic [1:0]        nrows_m1;
    logic              empty;
    logic              final_blk;
  } blk_ctx_t;

  // v*255/31 = 8v + floor(7v/31)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0] n;
    logic [2:0] q;
    logic [7:0] r;
    n = {v, 3'b000} - {3'b000, v};
    q = n[7:5];
    r = n - ({q, 5'b00000} - {5'b00000, q});
    if (r >= 8'd31) begin
      q = q + 3'd1;
    end
    return {v, 3'b000} + {5'b00000, q};
  endfunction

  // v*255/63 = 4v + floor(v/21)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    if (v >= 6'd63) begin
      q = 2'd3;
    end else if (v >= 6'd42) begin
      q = 2'd2;
    end else if (v >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return {v, 2'b00} + {6'b000000, q};
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [DIV3_SH+9:0] p;
    p = (DIV3_SH+10)'(n) * (DIV3_SH+10)'(DIV3_MUL);
    return p[DIV3_SH +: 8];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [DIV5_SH+10:0] p;
    p = (DIV5_SH+11)'(n) * (DIV5_SH+11)'(DIV5_MUL);
    return p[DIV5_SH +: 8];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [DIV7_SH+10:0] p;
    p = (DIV7_SH+11)'(n) * (DIV7_SH+11)'(DIV7_MUL);
    return p[DIV7_SH +: 8];
  endfunction

  // interpolated alpha table, weights are constants per entry
  function automatic logic [7:0][7:0] alpha_table(input logic [7:0] a0,
                                                  input logic [7:0] a1);
    logic [7:0][7:0] t;
    logic [10:0]     s;
    t    = '0;
    t[0] = a0;
    t[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i < 7; i++) begin
        s = 11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
        t[i+1] = div7(s);
      end
    end else begin
      for (int i = 1; i < 5; i++) begin
        s = 11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
        t[i+1] = div5(s);
      end
      t[6] = 8'h00;
      t[7] = 8'hff;
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/s3tcd_blk_setup.sv =====
// ----------------------------------------------------------------------------
// S3TC block setup
// Builds the color palette, alpha table and clip extent of a held block.
// ----------------------------------------------------------------------------
module s3tcd_blk_setup import s3tcd_pkg::*; (
  input  fmt_t        mode,
  input  logic [15:0] img_w,
  input  logic [15:0] img_h,
  input  logic [63:0] cw,
  input  logic [63:0] aw,
  input  logic [13:0] col,
  input  logic [13:0] row,
  input  logic        final_blk,
  output blk_ctx_t    ctx
);

  logic [15:0]      c0;
  logic [15:0]      c1;
  logic [2:0][7:0]  e0;
  logic [2:0][7:0]  e1;
  logic [2:0][7:0]  m2;
  logic [2:0][7:0]  m3;
  logic             four;
  logic [15:0]      xbase;
  logic [15:0]      ybase;
  logic [15:0]      xrem;
  logic [15:0]      yrem;
  logic             x_out;
  logic             y_out;

  assign c0 = cw[15:0];
  assign c1 = cw[31:16];
  assign four = (mode != FMT_DXT1) || (c0 > c1);

  // channel order blue, green, red
  assign e0[0] = expand5(c0[4:0]);
  assign e0[1] = expand6(c0[10:5]);
  assign e0[2] = expand5(c0[15:11]);
  assign e1[0] = expand5(c1[4:0]);
  assign e1[1] = expand6(c1[10:5]);
  assign e1[2] = expand5(c1[15:11]);

  always_comb begin
    logic [8:0] half;
    for (int ch = 0; ch < 3; ch++) begin
      half = {1'b0, e0[ch]} + {1'b0, e1[ch]};
      if (four) begin
        m2[ch] = div3({1'b0, e0[ch], 1'b0} + {2'b00, e1[ch]});
        m3[ch] = div3({2'b00, e0[ch]} + {1'b0, e1[ch], 1'b0});
      end else begin
        m2[ch] = half[8:1];
        m3[ch] = 8'h00;
      end
    end
  end

  assign xbase = {col, 2'b00};
  assign ybase = {row, 2'b00};
  assign x_out = xbase >= img_w;
  assign y_out = ybase >= img_h;
  assign xrem  = img_w - xbase;
  assign yrem  = img_h - ybase;

  always_comb begin
    ctx.pal[0]      = '{blue: e0[0], green: e0[1], red: e0[2]};
    ctx.pal[1]      = '{blue: e1[0], green: e1[1], red: e1[2]};
    ctx.pal[2]      = '{blue: m2[0], green: m2[1], red: m2[2]};
    ctx.pal[3]      = '{blue: m3[0], green: m3[1], red: m3[2]};
    ctx.three_color = !four;
    ctx.mode        = mode;
    ctx.cidx        = cw[63:32];
    ctx.aw          = aw;
    ctx.atab        = alpha_table(aw[7:0], aw[15:8]);
    ctx.col         = col;
    ctx.row         = row;
    ctx.ncols_m1    = (xrem >= 16'd4) ? 2'd3 : 2'(xrem - 16'd1);
    ctx.nrows_m1    = (yrem >= 16'd4) ? 2'd3 : 2'(yrem - 16'd1);
    ctx.empty       = x_out || y_out;
    ctx.final_blk   = final_blk;
  end

endmodule

// ===== hw/rtl/s3tcd_texel_gen.sv =====
// ----------------------------------------------------------------------------
// S3TC texel generator
// Holds one set-up block and emits its in-image texels, one a cycle unless out_stall holds the output word.
// ----------------------------------------------------------------------------
`include "s3tc_block_texel_decoder_assert.svh"

module s3tcd_texel_gen import s3tcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  blk_ctx_t    ld_ctx,
  input  logic        ld_valid,
  output logic        ld_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic [15:0] out_pixel_x,
  output logic [15:0] out_pixel_y,
  output logic        out_block_last,
  output logic        out_image_last
);

  blk_ctx_t         ctx_r;
  logic             act_r;
  logic             act_nxt;
  logic [1:0]       tx_r;
  logic [1:0]       tx_nxt;
  logic [1:0]       ty_r;
  logic [1:0]       ty_nxt;
  logic             ov_r;
  logic             ov_nxt;
  logic [7:0]       blue_r;
  logic [7:0]       green_r;
  logic [7:0]       red_r;
  logic [7:0]       alpha_r;
  logic [15:0]      px_r;
  logic [15:0]      py_r;
  logic             blast_r;
  logic             ilast_r;

  logic             out_ok;
  logic             step;
  logic             last_tex;
  logic [3:0]       ti;
  logic [1:0]       idx;
  color_t           col_sel;
  logic [7:0]       alpha_sel;
  logic [15:0][3:0] anib;
  logic [15:0][2:0] a3;

  assign out_ok   = !ov_r || !out_stall;
  assign step     = act_r && out_ok;
  assign last_tex = (tx_r == ctx_r.ncols_m1) && (ty_r == ctx_r.nrows_m1);
  // slot frees on the final texel, so the next block follows without a gap
  assign ld_take  = ld_valid && (!act_r || (step && last_tex));

  assign ti      = {ty_r, tx_r};
  assign idx     = ctx_r.cidx[ti];
  assign col_sel = ctx_r.pal[idx];
  assign anib    = ctx_r.aw;
  assign a3      = ctx_r.aw[63:16];

  always_comb begin
    case (ctx_r.mode)
      FMT_DXT3: alpha_sel = {anib[ti], anib[ti]};
      FMT_DXT5: alpha_sel = ctx_r.atab[a3[ti]];
      default: begin
        alpha_sel = (ctx_r.three_color && (idx == 2'd3)) ? 8'h00 : 8'hff;
      end
    endcase
  end

  always_comb begin
    act_nxt = act_r;
    tx_nxt  = tx_r;
    ty_nxt  = ty_r;
    if (ld_take) begin
      act_nxt = !ld_ctx.empty;
      tx_nxt  = 2'd0;
      ty_nxt  = 2'd0;
    end else if (step) begin
      if (last_tex) begin
        act_nxt = 1'b0;
      end
      if (tx_r == ctx_r.ncols_m1) begin
        tx_nxt = 2'd0;
        ty_nxt = ty_r + 2'd1;
      end else begin
        tx_nxt = tx_r + 2'd1;
      end
    end
    ov_nxt = out_ok ? step : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      tx_r  <= 2'd0;
      ty_r  <= 2'd0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_take) begin
      ctx_r <= ld_ctx;
    end
    if (step) begin
      blue_r  <= col_sel.blue;
      green_r <= col_sel.green;
      red_r   <= col_sel.red;
      alpha_r <= alpha_sel;
      px_r    <= {ctx_r.col, tx_r};
      py_r    <= {ctx_r.row, ty_r};
      blast_r <= last_tex;
      ilast_r <= last_tex && ctx_r.final_blk;
    end
  end

  assign out_valid      = ov_r;
  assign out_blue       = blue_r;
  assign out_green      = green_r;
  assign out_red        = red_r;
  assign out_alpha      = alpha_r;
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_block_last = blast_r;
  assign out_image_last = ilast_r;

  `S3TCD_ASSERT_NOW(a_walk_in_clip, clk, rst_n, act_r, (tx_r <= ctx_r.ncols_m1) && (ty_r <= ctx_r.nrows_m1), "texel walk outside block clip")
  `S3TCD_ASSERT_NEXT(a_empty_no_walk, clk, rst_n, ld_take && ld_ctx.empty, !act_r, "empty block started a walk")
  `S3TCD_ASSERT_NEXT(a_last_frees, clk, rst_n, step && last_tex && !ld_take, !act_r, "slot still busy after last texel")
  `S3TCD_ASSERT_NOW(a_ilast_blast, clk, rst_n, ov_r && ilast_r, blast_r, "image end without block end")

endmodule

// ===== hw/rtl/s3tc_block_texel_decoder.sv =====
// ----------------------------------------------------------------------------
// S3TC block texel decoder
// Decodes DXT1/DXT3/DXT5 4x4 blocks into clipped, positioned texels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one compressed block per word (color half, alpha half), blocks in
//          raster block order; a word is taken when in_valid is high and
//          in_stall is low.
//   out_*  one texel per word, row-major inside the block, texels outside the
//          image are dropped; block_last / image_last flag the final texel.
//   cfg_*  register writes (format, width, height), always ready; write only
//          while no block is in flight.
//   Path: the first texel of a block passes the input holding register, the
//   texel slot and the output register. Throughput: one texel per cycle while
//   out_stall is low; a full block gives 16 texels, edge blocks give only their
//   in-image texels, and a block fully outside the image gives none. The texel
//   walk over the held block sets this rate.
//   Reset: registers return to DXT1, 4x4 image, block position at origin.
//   Stall: out_stall freezes the output word; the texel walk and then the
//   input holding register fill up and in_stall rises.
// ----------------------------------------------------------------------------
module s3tc_block_texel_decoder import s3tcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_color_word,
  input  logic [63:0] in_alpha_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic [15:0] out_pixel_x,
  output logic [15:0] out_pixel_y,
  output logic        out_block_last,
  output logic        out_image_last
);

  logic [1:0]  fmt_r;
  logic [1:0]  fmt_nxt;
  logic [15:0] img_w_r;
  logic [15:0] img_w_nxt;
  logic [15:0] img_h_r;
  logic [15:0] img_h_nxt;
  logic [13:0] pos_col_r;
  logic [13:0] pos_col_nxt;
  logic [13:0] pos_row_r;
  logic [13:0] pos_row_nxt;
  logic        blk_v_r;
  logic        blk_v_nxt;
  logic [63:0] blk_cw_r;
  logic [63:0] blk_aw_r;
  logic [13:0] blk_col_r;
  logic [13:0] blk_row_r;
  logic        blk_final_r;

  fmt_t        mode;
  logic [15:0] w_eff;
  logic [15:0] h_eff;
  logic [16:0] bx_sum;
  logic [16:0] by_sum;
  logic [14:0] bx;
  logic [14:0] by;
  logic [14:0] col_p1;
  logic [14:0] row_p1;
  logic        final_now;
  logic        in_acc;
  logic        cfg_wr;
  logic        ld_take;
  blk_ctx_t    ld_ctx;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    case (fmt_r)
      FMT_DXT3: mode = FMT_DXT3;
      FMT_DXT5: mode = FMT_DXT5;
      default:  mode = FMT_DXT1;
    endcase
  end

  assign w_eff  = (img_w_r == 16'd0) ? 16'd1 : img_w_r;
  assign h_eff  = (img_h_r == 16'd0) ? 16'd1 : img_h_r;
  assign bx_sum = {1'b0, w_eff} + 17'd3;
  assign by_sum = {1'b0, h_eff} + 17'd3;
  assign bx     = bx_sum[16:2];
  assign by     = by_sum[16:2];
  assign col_p1 = {1'b0, pos_col_r} + 15'd1;
  assign row_p1 = {1'b0, pos_row_r} + 15'd1;
  assign final_now = ({1'b0, pos_col_r} == bx - 15'd1) &&
                     ({1'b0, pos_row_r} == by - 15'd1);

  assign in_stall = blk_v_r && !ld_take;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    fmt_nxt   = fmt_r;
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    if (cfg_wr) begin
      case (cfg_index)
        CFG_FORMAT_MODE:  fmt_nxt   = cfg_data[1:0];
        CFG_IMAGE_WIDTH:  img_w_nxt = cfg_data;
        CFG_IMAGE_HEIGHT: img_h_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // block position steps on every accepted word and wraps at the grid end
  always_comb begin
    pos_col_nxt = pos_col_r;
    pos_row_nxt = pos_row_r;
    if (in_acc) begin
      if (col_p1 >= bx) begin
        pos_col_nxt = 14'd0;
        pos_row_nxt = (row_p1 >= by) ? 14'd0 : row_p1[13:0];
      end else begin
        pos_col_nxt = col_p1[13:0];
      end
    end
    blk_v_nxt = in_acc || (blk_v_r && !ld_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= 2'd0;
      img_w_r   <= 16'd4;
      img_h_r   <= 16'd4;
      pos_col_r <= 14'd0;
      pos_row_r <= 14'd0;
      blk_v_r   <= 1'b0;
    end else begin
      fmt_r     <= fmt_nxt;
      img_w_r   <= img_w_nxt;
      img_h_r   <= img_h_nxt;
      pos_col_r <= pos_col_nxt;
      pos_row_r <= pos_row_nxt;
      blk_v_r   <= blk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_cw_r    <= in_color_word;
      blk_aw_r    <= in_alpha_word;
      blk_col_r   <= pos_col_r;
      blk_row_r   <= pos_row_r;
      blk_final_r <= final_now;
    end
  end

  s3tcd_blk_setup u_setup (
    .mode      (mode),
    .img_w     (w_eff),
    .img_h     (h_eff),
    .cw        (blk_cw_r),
    .aw        (blk_aw_r),
    .col       (blk_col_r),
    .row       (blk_row_r),
    .final_blk (blk_final_r),
    .ctx       (ld_ctx)
  );

  s3tcd_texel_gen u_texel (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld_ctx         (ld_ctx),
    .ld_valid       (blk_v_r),
    .ld_take        (ld_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_alpha      (out_alpha),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_block_last (out_block_last),
    .out_image_last (out_image_last)
  );

endmodule

// ===== dv/tb_s3tc_block_texel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3TC block texel decoder testbench
// Drives compressed blocks under DXT1/DXT3/DXT5 and several image sizes,
// predicts every clipped texel, and checks each output word in order while
// both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_s3tc_block_texel_decoder;
  import s3tcd_pkg::*;

  localparam logic [1:0] FMT_UNUSED      = 2'd3;
  localparam logic [1:0] CFG_NONE        = 2'd3;
  localparam int         SETTLE_CYCLES   = 20;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         CYCLE_LIMIT     = 300000;
  localparam int         RANDOM_BLOCKS   = 96;

  typedef struct {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic        block_last;
    logic        image_last;
  } texel_t;

  // predicts the texels of each accepted block and checks them in order
  class texel_decode_model;
    logic [1:0]  fmt_reg;
    logic [15:0] img_w;
    logic [15:0] img_h;
    int unsigned blk_col;
    int unsigned blk_row;
    texel_t      texels_due[$];
    int          errors;

    function new();
      fmt_reg = FMT_DXT1;
      img_w   = 16'd4;
      img_h   = 16'd4;
      blk_col = 0;
      blk_row = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] data);
      case (index)
        CFG_FORMAT_MODE:  fmt_reg = data[1:0];
        CFG_IMAGE_WIDTH:  img_w = data;
        CFG_IMAGE_HEIGHT: img_h = data;
        default: ;
      endcase
    endfunction

    function int unsigned widen5(int unsigned v);
      return ((v & 32'h1f) * 255) / 31;
    endfunction

    function int unsigned widen6(int unsigned v);
      return ((v & 32'h3f) * 255) / 63;
    endfunction

    function void take_block(logic [63:0] cw, logic [63:0] aw);
      int unsigned w, h, nbx, nby, c0, c1, a0, a1, px, py, idx, av;
      int unsigned pal[4][4];
      int unsigned atab[8];
      fmt_t        mode;
      bit          four_color, final_blk;
      texel_t      t;
      texel_t      blk[$];
      w   = (img_w == 0) ? 1 : 32'(img_w);
      h   = (img_h == 0) ? 1 : 32'(img_h);
      nbx = (w + 3) / 4;
      nby = (h + 3) / 4;
      mode = (fmt_reg == FMT_DXT3 || fmt_reg == FMT_DXT5) ? fmt_t'(fmt_reg) : FMT_DXT1;
      c0 = 32'(cw[15:0]);
      c1 = 32'(cw[31:16]);
      four_color = (mode != FMT_DXT1) || (c0 > c1);
      final_blk  = (blk_col == nbx - 1) && (blk_row == nby - 1);

      pal[0][0] = widen5(c0);
      pal[0][1] = widen6(c0 >> 5);
      pal[0][2] = widen5(c0 >> 11);
      pal[0][3] = 255;
      pal[1][0] = widen5(c1);
      pal[1][1] = widen6(c1 >> 5);
      pal[1][2] = widen5(c1 >> 11);
      pal[1][3] = 255;
      for (int ch = 0; ch < 3; ch++) begin
        if (four_color) begin
          pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
          pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
        end else begin
          pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
          pal[3][ch] = 0;
        end
      end
      pal[2][3] = 255;
      pal[3][3] = four_color ? 255 : 0;

      a0 = 32'(aw[7:0]);
      a1 = 32'(aw[15:8]);
      atab[0] = a0;
      atab[1] = a1;
      if (a0 > a1) begin
        for (int k = 1; k < 7; k++) atab[k+1] = ((7 - k) * a0 + k * a1) / 7;
      end else begin
        for (int k = 1; k < 5; k++) atab[k+1] = ((5 - k) * a0 + k * a1) / 5;
        atab[6] = 0;
        atab[7] = 255;
      end

      for (int i = 0; i < 16; i++) begin
        px  = blk_col * 4 + (i % 4);
        py  = blk_row * 4 + (i / 4);
        idx = 32'(cw[32 + 2 * i +: 2]);
        if (px < w && py < h) begin
          case (mode)
            FMT_DXT3: av = 32'(aw[4 * i +: 4]) * 17;
            FMT_DXT5: av = atab[aw[16 + 3 * i +: 3]];
            default:  av = pal[idx][3];
          endcase
          t.blue       = 8'(pal[idx][0]);
          t.green      = 8'(pal[idx][1]);
          t.red        = 8'(pal[idx][2]);
          t.alpha      = 8'(av);
          t.pixel_x    = 16'(px);
          t.pixel_y    = 16'(py);
          t.block_last = 1'b0;
          t.image_last = 1'b0;
          blk = {blk, t};
        end
      end
      if (blk.size() > 0) begin
        blk[blk.size() - 1].block_last = 1'b1;
        blk[blk.size() - 1].image_last = final_blk;
      end
      texels_due = {texels_due, blk};

      // position wraps even when it sits past a shrunken grid
      if (blk_col + 1 >= nbx) begin
        blk_col = 0;
        blk_row = (blk_row + 1 >= nby) ? 0 : ((blk_row + 1) & 32'h3fff);
      end else begin
        blk_col = (blk_col + 1) & 32'h3fff;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_texel(texel_t got);
      texel_t want;
      if (texels_due.size() == 0) begin
        $error("texel at (%0d,%0d) with none expected", got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = texels_due.pop_front();
      compare_field("blue", want.blue, got.blue);
      compare_field("green", want.green, got.green);
      compare_field("red", want.red, got.red);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("block_last", want.block_last, got.block_last);
      compare_field("image_last", want.image_last, got.image_last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_color_word;
  logic [63:0] in_alpha_word;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_alpha;
  logic [15:0] out_pixel_x;
  logic [15:0] out_pixel_y;
  logic        out_block_last;
  logic        out_image_last;

  texel_decode_model dec;
  int                burst_left = 0;
  int                cycle_count = 0;
  logic              hold_off_go = 1'b0;

  s3tc_block_texel_decoder u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_color_word (in_color_word),
    .in_alpha_word (in_alpha_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_alpha     (out_alpha),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_block_last(out_block_last),
    .out_image_last(out_image_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sampled mid-cycle: a word seen here is taken at the next rising edge
  always @(negedge clk) begin : texel_monitor
    texel_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.blue       = out_blue;
      got.green      = out_green;
      got.red        = out_red;
      got.alpha      = out_alpha;
      got.pixel_x    = out_pixel_x;
      got.pixel_y    = out_pixel_y;
      got.block_last = out_block_last;
      got.image_last = out_image_last;
      dec.check_texel(got);
    end
  end

  // receiver stall pattern: free, light and heavy stretches, plus one long hold
  initial begin : rx_pacing
    int stretch;
    int level;
    int hold_left;
    bit hold_done;
    stretch   = 0;
    level     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stretch == 0) begin
          level   = $urandom_range(0, 2);
          stretch = $urandom_range(10, 60);
        end
        stretch--;
        case (level)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  function automatic logic [63:0] rand_color_word();
    logic [63:0] cw;
    cw = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) cw[31:16] = cw[15:0];
    return cw;
  endfunction

  function automatic logic [63:0] rand_alpha_word();
    logic [63:0] aw;
    aw = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) aw[15:8] = aw[7:0];
    return aw;
  endfunction

  task automatic send_block(input logic [63:0] cw, input logic [63:0] aw);
    int gap;
    in_valid      <= 1'b1;
    in_color_word <= cw;
    in_alpha_word <= aw;
    do @(negedge clk); while (in_stall);
    dec.take_block(cw, aw);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 10);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (dec.texels_due.size() != 0) @(posedge clk);
    // clipped blocks make no texels but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg_word(input logic [1:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    dec.write_reg(index, data);
    @(posedge clk);
  endtask

  task automatic set_image(input logic [1:0] fmt, input logic [15:0] w,
                           input logic [15:0] h);
    write_reg_word(CFG_FORMAT_MODE, {14'd0, fmt});
    write_reg_word(CFG_IMAGE_WIDTH, w);
    write_reg_word(CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main_seq
    int          sent;
    int          nblk;
    int          r;
    logic [1:0]  fmt;
    logic [15:0] w;
    logic [15:0] h;
    dec           = new();
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_FORMAT_MODE;
    cfg_data      = 16'd0;
    in_valid      = 1'b0;
    in_color_word = 64'd0;
    in_alpha_word = 64'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: dxt1 on a single 4x4 block
    send_block(64'd0, 64'd0);
    send_block({64{1'b1}}, {64{1'b1}});
    send_block({32'hE4E4E4E4, 16'h001F, 16'hF800}, rand_alpha_word());
    send_block({32'h1B1B1B1B, 16'hFFFF, 16'h0000}, 64'd0);
    wait_drained();

    set_image(FMT_DXT3, 16'd4, 16'd4);
    send_block({32'hE4E4E4E4, 16'h001F, 16'hF800}, 64'hFEDCBA9876543210);
    send_block({32'h1B1B1B1B, 16'h0000, 16'h0000}, {64{1'b1}});
    wait_drained();

    // alpha indices walk 0..7 twice
    set_image(FMT_DXT5, 16'd4, 16'd4);
    send_block(rand_color_word(), 64'hFAC688FAC68800FF);
    send_block(rand_color_word(), 64'hFAC688FAC688C010);
    send_block(rand_color_word(), 64'hFAC688FAC6885A5A);
    wait_drained();

    // unused format falls back to dxt1
    set_image(FMT_UNUSED, 16'd4, 16'd4);
    send_block({32'h1B1B1B1B, 16'hFFFF, 16'h0000}, {64{1'b1}});
    wait_drained();

    // zero size acts as a single texel
    set_image(FMT_DXT1, 16'd0, 16'd0);
    send_block(rand_color_word(), rand_alpha_word());
    send_block(rand_color_word(), rand_alpha_word());
    wait_drained();

    // edge clipping and wrap back to the first block
    set_image(FMT_DXT5, 16'd5, 16'd6);
    repeat (5) send_block(rand_color_word(), rand_alpha_word());
    wait_drained();

    set_image(FMT_DXT3, 16'd13, 16'd13);
    repeat (5) send_block(rand_color_word(), rand_alpha_word());
    wait_drained();

    // shrink with the position beyond the new grid
    set_image(FMT_DXT1, 16'd4, 16'd4);
    send_block(rand_color_word(), rand_alpha_word());
    send_block(rand_color_word(), rand_alpha_word());
    wait_drained();

    write_reg_word(CFG_NONE, 16'hFFFF);
    cfg_valid <= 1'b0;
    set_image(FMT_DXT1, 16'hFFFF, 16'hFFFF);
    send_block(rand_color_word(), rand_alpha_word());
    wait_drained();

    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      r   = $urandom_range(0, 9);
      fmt = (r < 3) ? FMT_DXT1 : (r < 6) ? FMT_DXT3 : (r < 9) ? FMT_DXT5 : FMT_UNUSED;
      r   = $urandom_range(0, 9);
      w   = (r < 8) ? 16'($urandom_range(1, 24)) : (r == 8) ? 16'hFFFF
                                                             : 16'($urandom_range(0, 65535));
      r   = $urandom_range(0, 9);
      h   = (r < 8) ? 16'($urandom_range(1, 24)) : (r == 8) ? 16'hFFFF
                                                             : 16'($urandom_range(0, 65535));
      nblk = $urandom_range(8, 24);
      if (sent == 0) begin
        w = 16'd16;
        h = 16'd16;
      end
      set_image(fmt, w, h);
      // first phase: long receiver hold so the block backs up into in_stall
      if (sent == 0) hold_off_go <= 1'b1;
      repeat (nblk) send_block(rand_color_word(), rand_alpha_word());
      sent += nblk;
      wait_drained();
    end

    if (dec.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== s3tc_block_texel_decoder.f =====
+incdir+hw/rtl
hw/rtl/s3tcd_pkg.sv
hw/rtl/s3tcd_blk_setup.sv
hw/rtl/s3tcd_texel_gen.sv
hw/rtl/s3tc_block_texel_decoder.sv
dv/tb_s3tc_block_texel_decoder.sv
